// File: design/wnpm_pkg.sv
// Shared types and constants for the wildcard nibble pattern matcher.
// No dependencies; used by every module of the block.
package wnpm_pkg;

    localparam int MAX_NIBBLES_DEF = 16;
    localparam int INDEX_BITS_DEF  = 32;

    localparam int PAT_BITS    = 64;
    localparam int CARE_BITS   = 16;
    localparam int LEN_BITS    = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int START_BITS  = 32;
    localparam int MIN_LENGTH  = 3;

    localparam int IN_DATA_BITS  = 8;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_DATA_BITS = 72;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CARE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH  = 2'd2;

    localparam logic [PAT_BITS-1:0]  PATTERN_RST = '0;
    localparam logic [CARE_BITS-1:0] CARE_RST    = '1;
    localparam logic [LEN_BITS-1:0]  LENGTH_RST  = 5'd16;

    // pattern re-ordered so that window nibble j (0 = newest) lines up with pat[4j+:4]
    typedef struct packed {
        logic [PAT_BITS-1:0]  pat;
        logic [CARE_BITS-1:0] care;
        logic [LEN_BITS-1:0]  len;
        logic [LEN_BITS-1:0]  len_m1;
    } t_match_cfg;

endpackage

// File: design/wnpm_cfg.sv
// Configuration registers and the aligned pattern/care view derived from them.
// Depends on wnpm_pkg.
module wnpm_cfg #(
    parameter int MAX_NIBBLES = wnpm_pkg::MAX_NIBBLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wnpm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wnpm_pkg::PAT_BITS-1:0]      i_cfg_data,
    output wnpm_pkg::t_match_cfg               o_cfg
);

    logic [wnpm_pkg::PAT_BITS-1:0]  r_pattern;
    logic [wnpm_pkg::CARE_BITS-1:0] r_care;
    logic [wnpm_pkg::LEN_BITS-1:0]  r_length;

    wnpm_pkg::t_match_cfg r_cfg, n_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= wnpm_pkg::PATTERN_RST;
            r_care    <= wnpm_pkg::CARE_RST;
            r_length  <= wnpm_pkg::LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wnpm_pkg::CFG_PATTERN: r_pattern <= i_cfg_data;
                wnpm_pkg::CFG_CARE:    r_care    <= i_cfg_data[wnpm_pkg::CARE_BITS-1:0];
                wnpm_pkg::CFG_LENGTH:  r_length  <= i_cfg_data[wnpm_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [wnpm_pkg::LEN_BITS-1:0] v_len;
        logic [3:0]                    v_sel;
        v_len = r_length;
        if (v_len < wnpm_pkg::LEN_BITS'(wnpm_pkg::MIN_LENGTH)) begin
            v_len = wnpm_pkg::LEN_BITS'(wnpm_pkg::MIN_LENGTH);
        end
        if (v_len > wnpm_pkg::LEN_BITS'(MAX_NIBBLES)) begin
            v_len = wnpm_pkg::LEN_BITS'(MAX_NIBBLES);
        end
        n_cfg.len    = v_len;
        n_cfg.len_m1 = v_len - 5'd1;
        n_cfg.pat    = '0;
        n_cfg.care   = '0;
        for (int j = 0; j < wnpm_pkg::CARE_BITS; j++) begin
            v_sel = 4'(n_cfg.len_m1 - wnpm_pkg::LEN_BITS'(j));
            if (wnpm_pkg::LEN_BITS'(j) < v_len) begin
                n_cfg.pat[4*j +: 4] = r_pattern[4*v_sel +: 4];
                n_cfg.care[j]       = r_care[v_sel];
            end
        end
    end

    // derived view is registered from the raw registers; writes must happen only when idle, not enforced here
    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/wnpm_cmp.sv
// One nibble step: window compare against the aligned pattern and state update.
// Depends on wnpm_pkg.
module wnpm_cmp #(
    parameter int MAX_NIBBLES = wnpm_pkg::MAX_NIBBLES_DEF,
    parameter int INDEX_BITS  = wnpm_pkg::INDEX_BITS_DEF,
    localparam int WIN_BITS   = 4 * (MAX_NIBBLES - 1),
    localparam int SEEN_BITS  = $clog2(MAX_NIBBLES + 1)
) (
    input  wnpm_pkg::t_match_cfg  i_cfg,
    input  logic [WIN_BITS-1:0]   i_win,
    input  logic [SEEN_BITS-1:0]  i_seen,
    input  logic [INDEX_BITS-1:0] i_idx,
    input  logic [3:0]            i_nib,
    output logic                  o_hit,
    output logic [INDEX_BITS-1:0] o_start,
    output logic [WIN_BITS-1:0]   o_win,
    output logic [SEEN_BITS-1:0]  o_seen,
    output logic [INDEX_BITS-1:0] o_idx
);

    logic [4*MAX_NIBBLES-1:0] hist;
    logic [MAX_NIBBLES-1:0]   pos_ok;
    logic                     full_ok;

    assign hist = {i_win, i_nib};

    always_comb begin
        for (int j = 0; j < MAX_NIBBLES; j++) begin
            pos_ok[j] = !i_cfg.care[j] || (hist[4*j +: 4] == i_cfg.pat[4*j +: 4]);
        end
    end

    assign full_ok = (6'(i_seen) + 6'd1) >= 6'(i_cfg.len);
    assign o_hit   = full_ok && (&pos_ok);
    assign o_start = o_hit ? (i_idx - INDEX_BITS'(i_cfg.len_m1)) : '0;

    assign o_win  = hist[WIN_BITS-1:0];
    assign o_seen = (i_seen == SEEN_BITS'(MAX_NIBBLES)) ? i_seen : i_seen + 1'b1;
    assign o_idx  = i_idx + 1'b1;

endmodule

// File: design/wildcard_nibble_pattern_matcher.sv
// Top level of the wildcard nibble pattern matcher: stream ports, input and result registers.
// Depends on wnpm_pkg, wnpm_cfg and wnpm_cmp.
//
//  channel   | direction | transfer carries
//  s_axis    | in        | tdata: data_byte [7:0]; tuser: stream_start [0]
//  m_axis    | out       | tdata: hit_high, start_high, hit_low, start_low
//  cfg       | in        | register index and write data, no handshake
//
// One byte per cycle sustained while the result side is ready; an input transfer loads the input
// register, which then loads the result register from which the result transfer is made.
// The input register feeds two chained nibble compares that load the result register.
// A stalled result holds the input register; the input side keeps taking transfers
// while the input register is empty, or the result register is free or being drained.
// Reset (synchronous, active low) empties both registers and clears the window state.
module wildcard_nibble_pattern_matcher #(
    parameter int MAX_NIBBLES = wnpm_pkg::MAX_NIBBLES_DEF,
    parameter int INDEX_BITS  = wnpm_pkg::INDEX_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wnpm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [wnpm_pkg::PAT_BITS-1:0]        i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] data_byte
    input  logic [wnpm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // [0] stream_start
    input  logic [wnpm_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] hit_high, [32:1] start_high, [33] hit_low, [65:34] start_low, [71:66] zero
    output logic [wnpm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

    localparam int WIN_BITS  = 4 * (MAX_NIBBLES - 1);
    localparam int SEEN_BITS = $clog2(MAX_NIBBLES + 1);

    wnpm_pkg::t_match_cfg cfg;

    logic                                r_in_vld;
    logic [wnpm_pkg::IN_DATA_BITS-1:0]   r_in_byte;
    logic                                r_in_start;

    logic [WIN_BITS-1:0]                 r_win;
    logic [SEEN_BITS-1:0]                r_seen;
    logic [INDEX_BITS-1:0]               r_idx;

    logic                                r_out_vld;
    logic [wnpm_pkg::OUT_DATA_BITS-1:0]  r_out_data;

    logic                  proc;
    logic [WIN_BITS-1:0]   cur_win;
    logic [SEEN_BITS-1:0]  cur_seen;
    logic [INDEX_BITS-1:0] cur_idx;

    logic                  hi_hit,   lo_hit;
    logic [INDEX_BITS-1:0] hi_start, lo_start;
    logic [WIN_BITS-1:0]   hi_win,   lo_win;
    logic [SEEN_BITS-1:0]  hi_seen,  lo_seen;
    logic [INDEX_BITS-1:0] hi_idx,   lo_idx;

    wnpm_cfg #(
        .MAX_NIBBLES (MAX_NIBBLES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign proc          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || proc;

    assign cur_win  = r_in_start ? '0 : r_win;
    assign cur_seen = r_in_start ? '0 : r_seen;
    assign cur_idx  = r_in_start ? '0 : r_idx;

    wnpm_cmp #(
        .MAX_NIBBLES (MAX_NIBBLES),
        .INDEX_BITS  (INDEX_BITS)
    ) u_cmp_hi (
        .i_cfg   (cfg),
        .i_win   (cur_win),
        .i_seen  (cur_seen),
        .i_idx   (cur_idx),
        .i_nib   (r_in_byte[7:4]),
        .o_hit   (hi_hit),
        .o_start (hi_start),
        .o_win   (hi_win),
        .o_seen  (hi_seen),
        .o_idx   (hi_idx)
    );

    wnpm_cmp #(
        .MAX_NIBBLES (MAX_NIBBLES),
        .INDEX_BITS  (INDEX_BITS)
    ) u_cmp_lo (
        .i_cfg   (cfg),
        .i_win   (hi_win),
        .i_seen  (hi_seen),
        .i_idx   (hi_idx),
        .i_nib   (r_in_byte[3:0]),
        .o_hit   (lo_hit),
        .o_start (lo_start),
        .o_win   (lo_win),
        .o_seen  (lo_seen),
        .o_idx   (lo_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_seen <= '0;
            r_idx  <= '0;
        end else if (proc) begin
            r_win  <= lo_win;
            r_seen <= lo_seen;
            r_idx  <= lo_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_data <= {6'd0,
                           wnpm_pkg::START_BITS'(lo_start), lo_hit,
                           wnpm_pkg::START_BITS'(hi_start), hi_hit};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_BITS'(MAX_NIBBLES))
        else $error("nibble count beyond window depth");

    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_data[0]) |-> (r_out_data[32:1] == '0))
        else $error("start index set without a high-nibble hit");

    a_restart_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_start) |=> (r_idx == INDEX_BITS'(2)))
        else $error("nibble index not restarted by stream start");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !proc) |=> (r_in_vld && $stable(r_in_byte) && $stable(r_win)))
        else $error("held input or window changed during a stall");

endmodule

// File: test/wildcard_nibble_pattern_matcher_tb.sv
// Self-checking testbench for wildcard_nibble_pattern_matcher: directed and random byte streams
// against its own window predictor, with random gaps on both stream sides.
// Depends on wnpm_pkg and the design files only.
module wildcard_nibble_pattern_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [wnpm_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_PHASES = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic       stream_start;
        logic [7:0] data_byte;
    } t_scan_item;

    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] start_low;
        logic        hit_low;
        logic [31:0] start_high;
        logic        hit_high;
    } t_match_result;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     i_cfg_we = 1'b0;
    logic [wnpm_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx = wnpm_pkg::CFG_PATTERN;
    logic [wnpm_pkg::PAT_BITS-1:0]            i_cfg_data = '0;
    logic                                     s_axis_tvalid = 1'b0;
    logic                                     s_axis_tready;
    // [7:0] data_byte
    logic [wnpm_pkg::IN_DATA_BITS-1:0]        s_axis_tdata = '0;
    // [0] stream_start
    logic [wnpm_pkg::IN_USER_BITS-1:0]        s_axis_tuser = '0;
    logic                                     m_axis_tvalid;
    logic                                     m_axis_tready = 1'b0;
    // [0] hit_high, [32:1] start_high, [33] hit_low, [65:34] start_low, [71:66] zero
    logic [wnpm_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata;

    wildcard_nibble_pattern_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_scan_item    pending_bytes[$];
    t_match_result expected_matches[$];
    t_scan_item    drive_item;
    t_match_result pred_match;
    t_match_result got_match;
    t_match_result want_match;
    logic          steady_run = 1'b0;
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    // predictor copy of the registers and the window state
    logic [wnpm_pkg::PAT_BITS-1:0]  pat_q;
    logic [wnpm_pkg::CARE_BITS-1:0] care_q;
    logic [wnpm_pkg::LEN_BITS-1:0]  len_q;
    logic [59:0]                    window_q;
    logic [4:0]                     seen_q;
    logic [31:0]                    index_q;

    // generator view of the current setting
    logic [wnpm_pkg::PAT_BITS-1:0]  gen_pat;
    logic [wnpm_pkg::CARE_BITS-1:0] gen_care;
    int unsigned                    gen_span;

    function automatic int unsigned clamp_span(input logic [wnpm_pkg::LEN_BITS-1:0] len);
        int unsigned span;
        span = 32'(len);
        if (span < wnpm_pkg::MIN_LENGTH) span = wnpm_pkg::MIN_LENGTH;
        if (span > wnpm_pkg::MAX_NIBBLES_DEF) span = wnpm_pkg::MAX_NIBBLES_DEF;
        return span;
    endfunction

    function automatic void scan_nibble(input logic [3:0] nib, output logic hit,
                                        output logic [31:0] start_idx);
        logic [63:0] hist;
        int unsigned span;
        hist = {window_q, nib};
        span = clamp_span(len_q);
        hit = 1'b0;
        if (seen_q + 1 >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
                if (care_q[i] && hist[4*(span-1-i) +: 4] != pat_q[4*i +: 4]) hit = 1'b0;
            end
        end
        start_idx = hit ? index_q - 32'(span - 1) : '0;
        window_q = hist[59:0];
        if (seen_q < wnpm_pkg::MAX_NIBBLES_DEF) seen_q = seen_q + 1'b1;
        index_q = index_q + 1'b1;
    endfunction

    function automatic t_match_result scan_byte(input logic [7:0] data, input logic restart);
        t_match_result res;
        logic          hit;
        logic [31:0]   start_idx;
        res = '0;
        if (restart) begin
            window_q = '0;
            seen_q = '0;
            index_q = '0;
        end
        scan_nibble(data[7:4], hit, start_idx);
        res.hit_high = hit;
        res.start_high = start_idx;
        scan_nibble(data[3:0], hit, start_idx);
        res.hit_low = hit;
        res.start_low = start_idx;
        return res;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [71:0] want,
                                          input logic [71:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            pat_q = wnpm_pkg::PATTERN_RST;
            care_q = wnpm_pkg::CARE_RST;
            len_q = wnpm_pkg::LENGTH_RST;
            window_q = '0;
            seen_q = '0;
            index_q = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wnpm_pkg::CFG_PATTERN: pat_q = i_cfg_data;
                    wnpm_pkg::CFG_CARE:    care_q = i_cfg_data[wnpm_pkg::CARE_BITS-1:0];
                    wnpm_pkg::CFG_LENGTH:  len_q = i_cfg_data[wnpm_pkg::LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred_match = scan_byte(s_axis_tdata, s_axis_tuser[0]);
                expected_matches = {expected_matches, pred_match};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && (steady_run || $urandom_range(99) >= 15)) begin
                    drive_item = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= drive_item.data_byte;
                    s_axis_tuser <= drive_item.stream_start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_match = m_axis_tdata;
                if (expected_matches.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got_match);
                end else begin
                    want_match = expected_matches.pop_front();
                    if (got_match.hit_high !== want_match.hit_high)
                        flag_mismatch("hit_high", 72'(want_match.hit_high),
                                      72'(got_match.hit_high));
                    if (got_match.start_high !== want_match.start_high)
                        flag_mismatch("start_high", 72'(want_match.start_high),
                                      72'(got_match.start_high));
                    if (got_match.hit_low !== want_match.hit_low)
                        flag_mismatch("hit_low", 72'(want_match.hit_low),
                                      72'(got_match.hit_low));
                    if (got_match.start_low !== want_match.start_low)
                        flag_mismatch("start_low", 72'(want_match.start_low),
                                      72'(got_match.start_low));
                    if (got_match.pad !== want_match.pad)
                        flag_mismatch("padding", 72'(want_match.pad), 72'(got_match.pad));
                end
            end
            m_axis_tready <= steady_run || $urandom_range(99) >= 15;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [wnpm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [wnpm_pkg::PAT_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_matcher(input logic [wnpm_pkg::PAT_BITS-1:0] pat,
                                   input logic [wnpm_pkg::CARE_BITS-1:0] care,
                                   input logic [wnpm_pkg::LEN_BITS-1:0] len);
        write_reg(wnpm_pkg::CFG_LENGTH, {$urandom, 27'($urandom), len});
        write_reg(wnpm_pkg::CFG_CARE, {$urandom, 16'($urandom), care});
        write_reg(wnpm_pkg::CFG_PATTERN, pat);
        gen_pat = pat;
        gen_care = care;
        gen_span = clamp_span(len);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic restart);
        t_scan_item item;
        item.stream_start = restart;
        item.data_byte = data;
        pending_bytes = {pending_bytes, item};
    endtask

    // pattern copies with random wildcard nibbles, mixed with stray nibbles
    task automatic queue_matches(input int n_bytes);
        logic [3:0] nibs[$];
        while (nibs.size() < 2 * n_bytes) begin
            if ($urandom_range(2) == 0) begin
                nibs = {nibs, 4'($urandom)};
            end else begin
                for (int i = 0; i < gen_span; i++)
                    nibs = {nibs, (gen_care[i] ? gen_pat[4*i +: 4] : 4'($urandom))};
            end
        end
        for (int k = 0; k < n_bytes; k++)
            push_byte({nibs[2*k], nibs[2*k+1]},
                      (k == 0 && $urandom_range(1) == 0) || $urandom_range(60) == 0);
    endtask

    task automatic queue_noise(input int n_bytes);
        for (int k = 0; k < n_bytes; k++)
            push_byte(8'($urandom), $urandom_range(40) == 0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: sixteen zero nibbles, then a restart mid-stream
        @(negedge i_clk);
        for (int k = 0; k < 8; k++) push_byte(8'h00, k == 0);
        push_byte(8'hFF, 1'b1);
        wait_drained();

        // short length (below minimum), junk in unused nibbles, write to the spare index
        write_reg(wnpm_pkg::CFG_PATTERN, 64'hFFFF_FFFF_FFFF_FCBA);
        write_reg(wnpm_pkg::CFG_LENGTH, 64'd0);
        write_reg(CFG_SPARE, '1);
        @(negedge i_clk);
        push_byte(8'hAB, 1'b1);
        push_byte(8'hCA, 1'b0);
        push_byte(8'hBC, 1'b0);
        push_byte(8'hAB, 1'b0);
        wait_drained();

        // wildcard in the middle, length one taken as three
        write_reg(wnpm_pkg::CFG_CARE, 64'hFFFD);
        write_reg(wnpm_pkg::CFG_LENGTH, 64'd1);
        @(negedge i_clk);
        push_byte(8'hA5, 1'b1);
        push_byte(8'hCA, 1'b0);
        push_byte(8'h7C, 1'b0);
        wait_drained();

        // all wildcards, length above the maximum
        write_reg(wnpm_pkg::CFG_CARE, 64'h0000);
        write_reg(wnpm_pkg::CFG_LENGTH, 64'd17);
        @(negedge i_clk);
        for (int k = 0; k < 8; k++) push_byte(8'h12, k == 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: program_matcher({$urandom, $urandom}, '1, 5'd3);
                1: program_matcher({$urandom, $urandom}, 16'($urandom | $urandom), 5'd16);
                2: program_matcher({$urandom, $urandom}, '0, 5'd31);
                3: program_matcher({$urandom, $urandom}, 16'($urandom), 5'd2);
                default: program_matcher({$urandom, $urandom},
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom | $urandom),
                    ($urandom_range(7) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(3, 8)));
            endcase
            if ($urandom_range(3) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
            @(negedge i_clk);
            steady_run = (phase == 6);
            if (phase % 5 == 4)
                queue_noise($urandom_range(95, 115));
            else
                queue_matches($urandom_range(95, 115));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_matches.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: wildcard_nibble_pattern_matcher.f
design/wnpm_pkg.sv
design/wnpm_cfg.sv
design/wnpm_cmp.sv
design/wildcard_nibble_pattern_matcher.sv
test/wildcard_nibble_pattern_matcher_tb.sv
